// ===== src/lfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Framed log checker package
// Shared types, codes and the byte-wide CRC-32 table for the log frame
// checker.
// ----------------------------------------------------------------------------
package lfcc_pkg;

  localparam int unsigned LEN_W    = 24;
  localparam int unsigned CRC_W    = 32;
  localparam int unsigned STAMP_W  = 64;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned RECNUM_W = 32;

  localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [LEN_W-1:0] LEN_MAX      = 24'hFF_FFFF;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 24'h10_0000;

  // Request opcodes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_LEN_TOO_BIG  = 3'd1,
    ST_CRC_MISMATCH = 3'd2,
    ST_TORN_TAIL    = 3'd3,
    ST_CLEAN_END    = 3'd4
  } status_t;

  typedef struct packed {
    status_t               status;
    logic [RECNUM_W-1:0]   record_number;
    logic [LEN_W-1:0]      payload_length;
    logic [STAMP_W-1:0]    timestamp;
    logic [COUNT_W-1:0]    entry_count;
  } result_t;

  // Table entry of the reflected CRC-32 for one byte index.
  function automatic logic [CRC_W-1:0] crc_tbl(input logic [7:0] idx);
    logic [CRC_W-1:0] c;
    c = {24'h00_0000, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/lfcc_crc_step.sv =====
// ----------------------------------------------------------------------------
// CRC-32 byte step
// Advances a reflected CRC-32 register by one byte using a table lookup.
// ----------------------------------------------------------------------------
module lfcc_crc_step (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);
  import lfcc_pkg::*;

  assign crc_out = (crc_in >> 8) ^ crc_tbl(crc_in[7:0] ^ data);

endmodule

// ===== src/lfcc_parser.sv =====
// ----------------------------------------------------------------------------
// Record parser
// Walks the header and payload of each framed record, captures the
// timestamp and entry count, and decides the result for each request.
// ----------------------------------------------------------------------------
module lfcc_parser (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     opcode,
  input  logic [7:0]               data_byte,
  input  logic [lfcc_pkg::LEN_W-1:0] max_payload,
  output logic                     res_valid,
  output lfcc_pkg::result_t        res
);
  import lfcc_pkg::*;

  logic [3:0]          hdr_pos_r,   hdr_pos_nxt;
  logic [LEN_W-1:0]    len_r,       len_nxt;
  logic [CRC_W-1:0]    exp_crc_r,   exp_crc_nxt;
  logic [CRC_W-1:0]    crc_r,       crc_nxt;
  logic [LEN_W-1:0]    seen_r,      seen_nxt;
  logic [STAMP_W-1:0]  stamp_r,     stamp_nxt;
  logic [COUNT_W-1:0]  count_r,     count_nxt;
  logic [RECNUM_W-1:0] records_r,   records_nxt;
  logic                halted_r,    halted_nxt;

  logic [CRC_W-1:0]    crc_stepped;
  logic [CRC_W-1:0]    fin_crc;
  logic [CRC_W-1:0]    fin_exp;
  logic                finish;
  logic [LEN_W-1:0]    seen_inc;

  lfcc_crc_step u_crc (
    .crc_in  (crc_r),
    .data    (data_byte),
    .crc_out (crc_stepped)
  );

  assign seen_inc = seen_r + 1'b1;

  always_comb begin
    hdr_pos_nxt = hdr_pos_r;
    len_nxt     = len_r;
    exp_crc_nxt = exp_crc_r;
    crc_nxt     = crc_r;
    seen_nxt    = seen_r;
    stamp_nxt   = stamp_r;
    count_nxt   = count_r;
    records_nxt = records_r;
    halted_nxt  = halted_r;
    finish      = 1'b0;
    fin_crc     = crc_r ^ CRC_ALL_ONES;
    fin_exp     = exp_crc_r;
    res_valid   = 1'b0;
    res.status         = ST_OK;
    res.record_number  = records_r;
    res.payload_length = '0;
    res.timestamp      = '0;
    res.entry_count    = '0;

    if (step && !halted_r) begin
      if (opcode == OP_END) begin
        res_valid = 1'b1;
        if (hdr_pos_r != 4'd0) begin
          res.status = ST_TORN_TAIL;
          halted_nxt = 1'b1;
        end else begin
          res.status = ST_CLEAN_END;
        end
      end else if (hdr_pos_r < 4'd4) begin
        hdr_pos_nxt = hdr_pos_r + 4'd1;
        if (hdr_pos_r == 4'd3) begin
          // The top length byte is only kept implicitly: any non-zero value
          // is over every limit and halts the block.
          if (data_byte != 8'h00 || len_r > max_payload) begin
            res_valid          = 1'b1;
            res.status         = ST_LEN_TOO_BIG;
            res.payload_length = (data_byte != 8'h00) ? LEN_MAX : len_r;
            halted_nxt         = 1'b1;
          end
        end else begin
          len_nxt[hdr_pos_r[1:0]*8 +: 8] = data_byte;
        end
      end else if (hdr_pos_r < 4'd8) begin
        hdr_pos_nxt = hdr_pos_r + 4'd1;
        exp_crc_nxt[hdr_pos_r[1:0]*8 +: 8] = data_byte;
        if (hdr_pos_r == 4'd7 && len_r == '0) begin
          finish  = 1'b1;
          fin_exp = exp_crc_nxt;
        end
      end else begin
        crc_nxt  = crc_stepped;
        fin_crc  = crc_stepped ^ CRC_ALL_ONES;
        if (seen_r < 24'd8) begin
          stamp_nxt[seen_r[2:0]*8 +: 8] = data_byte;
        end else if (seen_r < 24'd12) begin
          count_nxt[seen_r[1:0]*8 +: 8] = data_byte;
        end
        seen_nxt = seen_inc;
        finish   = (seen_inc == len_r);
      end

      if (finish) begin
        res_valid          = 1'b1;
        res.payload_length = len_r;
        res.timestamp      = stamp_nxt;
        res.entry_count    = count_nxt;
        if (fin_crc == fin_exp) begin
          res.status = ST_OK;
          if (records_r != '1) begin
            records_nxt = records_r + 1'b1;
          end
          hdr_pos_nxt = 4'd0;
          len_nxt     = '0;
          exp_crc_nxt = '0;
          crc_nxt     = CRC_ALL_ONES;
          seen_nxt    = '0;
          stamp_nxt   = '0;
          count_nxt   = '0;
        end else begin
          res.status = ST_CRC_MISMATCH;
          halted_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r <= 4'd0;
      len_r     <= '0;
      exp_crc_r <= '0;
      crc_r     <= CRC_ALL_ONES;
      seen_r    <= '0;
      stamp_r   <= '0;
      count_r   <= '0;
      records_r <= '0;
      halted_r  <= 1'b0;
    end else begin
      hdr_pos_r <= hdr_pos_nxt;
      len_r     <= len_nxt;
      exp_crc_r <= exp_crc_nxt;
      crc_r     <= crc_nxt;
      seen_r    <= seen_nxt;
      stamp_r   <= stamp_nxt;
      count_r   <= count_nxt;
      records_r <= records_nxt;
      halted_r  <= halted_nxt;
    end
  end

endmodule

// ===== src/log_frame_crc_checker_core.sv =====
// ----------------------------------------------------------------------------
// Framed log record checker
// Checks length-framed records of a log byte stream against their CRC-32
// and reports one status per record end, bad length or end of log.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake          | Payload
//   in      | input     | in_valid/in_ready  | in_opcode, in_data_byte
//   out     | output    | out_valid/out_ready| status, record number, length,
//           |           |                    | timestamp, entry count
//   cfg     | input     | cfg_we             | cfg_wdata (max_payload)
//
// One request per clock while the output is not stalled: a request waits in the
// input register, where the byte-wide CRC table step and the record state update
// run, and its result, if any, is written into the output register as it moves on.
// A stalled output holds the input register, and in_ready drops while both
// registers are full and out_ready is low. Synchronous active-low reset returns
// to the start of a record with max_payload at 1 MiB; no clearing pass is needed.
// ----------------------------------------------------------------------------
module log_frame_crc_checker_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [7:0]                 in_data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic [31:0]                out_record_number,
  output logic [23:0]                out_payload_length,
  output logic [63:0]                out_timestamp,
  output logic [31:0]                out_entry_count,
  input  logic                       cfg_we,
  input  logic [lfcc_pkg::LEN_W-1:0] cfg_wdata
);
  import lfcc_pkg::*;

  logic             in_valid_r;
  logic             in_op_r;
  logic [7:0]       in_byte_r;
  logic             out_valid_r;
  result_t          out_res_r;
  logic [LEN_W-1:0] max_payload_r;

  logic             step;
  logic             res_valid;
  result_t          res;

  // The held request moves on whenever the output register can take a result.
  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  lfcc_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .opcode      (in_op_r),
    .data_byte   (in_byte_r),
    .max_payload (max_payload_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op_r   <= in_opcode;
      in_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_record_number  = out_res_r.record_number;
  assign out_payload_length = out_res_r.payload_length;
  assign out_timestamp      = out_res_r.timestamp;
  assign out_entry_count    = out_res_r.entry_count;

endmodule
